FILE: rtl/bsdf_pkg.sv
// Package for the scan duplicate filter: sizes, verdict and register codes,
// transfer payload types and the controller/datapath command and status groups.
// No dependencies.
package bsdf_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = 48;
    localparam int KIND_W      = 2;
    localparam int KEY_W       = ADDR_W + KIND_W;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 8;

    // Verdict codes
    localparam logic [2:0] VERDICT_ADDED    = 3'd0;
    localparam logic [2:0] VERDICT_NOT_CONN = 3'd1;
    localparam logic [2:0] VERDICT_WEAK     = 3'd2;
    localparam logic [2:0] VERDICT_FULL     = 3'd3;
    localparam logic [2:0] VERDICT_DUP      = 3'd4;
    localparam logic [2:0] VERDICT_CLEARED  = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RSSI_THRESHOLD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_MASK      = 8'd1;

    localparam logic signed [7:0] RSSI_THRESHOLD_RST = -8'sd50;
    localparam logic [7:0]        TYPE_MASK_RST      = 8'd35;

    localparam logic CMD_REPORT = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef struct packed {
        logic                cmd;
        logic [ADDR_W-1:0]   device_address;
        logic [KIND_W-1:0]   address_kind;
        logic [2:0]          advert_kind;
        logic signed [7:0]   signal_strength;
    } in_item_t;

    typedef struct packed {
        logic [2:0]          verdict;
        logic [3:0]          slot;
        logic [4:0]          entry_count;
    } out_item_t;

    typedef struct packed {
        logic                load_item;
        logic                set_verdict;
        logic [2:0]          verdict;
        logic                clear;
        logic                scan_start;
        logic                scan_en;
        logic                append;
        logic                load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic                is_clear;
        logic                not_conn;
        logic                low_signal;
        logic                full;
        logic                empty;
        logic                hit;
        logic                end_miss;
    } dp_status_t;

endpackage

FILE: rtl/bsdf_ctrl.sv
// Sequencing state machine of the scan duplicate filter.
// Depends on bsdf_pkg for the command and status groups and verdict codes.
module bsdf_ctrl
    import bsdf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_APPEND = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg & ~out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                priority if (status.is_clear)
                begin
                    cmd.clear       = 1'b1;
                    cmd.set_verdict = 1'b1;
                    cmd.verdict     = VERDICT_CLEARED;
                    state_next      = ST_DONE;
                end
                else if (status.not_conn)
                begin
                    cmd.set_verdict = 1'b1;
                    cmd.verdict     = VERDICT_NOT_CONN;
                    state_next      = ST_DONE;
                end
                else if (status.low_signal)
                begin
                    cmd.set_verdict = 1'b1;
                    cmd.verdict     = VERDICT_WEAK;
                    state_next      = ST_DONE;
                end
                else if (status.full)
                begin
                    cmd.set_verdict = 1'b1;
                    cmd.verdict     = VERDICT_FULL;
                    state_next      = ST_DONE;
                end
                else if (status.empty)
                begin
                    state_next = ST_APPEND;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
                priority if (status.hit)
                begin
                    cmd.set_verdict = 1'b1;
                    cmd.verdict     = VERDICT_DUP;
                    state_next      = ST_DONE;
                end
                else if (status.end_miss)
                begin
                    state_next = ST_APPEND;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_APPEND:
            begin
                cmd.append = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // wait for the output register to drain
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/bsdf_datapath.sv
// Datapath of the scan duplicate filter: configuration registers, item
// register, address table memory with its scan pipeline, entry count, result.
// Depends on bsdf_pkg.
module bsdf_datapath
    import bsdf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  in_item_t              in_item,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    output out_item_t             out_item
);

    logic signed [7:0] rssi_threshold_reg;
    logic [7:0]        type_mask_reg;
    in_item_t          item_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [2:0]        verdict_reg;
    logic [IDX_W-1:0]  slot_reg;
    out_item_t         out_reg;

    logic [KEY_W-1:0]  table_mem [TABLE_DEPTH];
    logic [KEY_W-1:0]  rd_data_reg;
    logic              rd_valid_reg;
    logic              rd_last_reg;
    logic [IDX_W-1:0]  scan_idx_reg;
    logic              issue_done_reg;

    logic [KEY_W-1:0]  key;
    logic [CNT_W-1:0]  scan_next_cnt;
    logic              scan_is_last;

    assign key           = {item_reg.address_kind, item_reg.device_address};
    assign scan_next_cnt = CNT_W'(scan_idx_reg) + CNT_W'(1);
    assign scan_is_last  = (scan_next_cnt == count_reg);

    always_comb
    begin
        status.is_clear   = (item_reg.cmd == CMD_CLEAR);
        status.not_conn   = ~type_mask_reg[item_reg.advert_kind];
        status.low_signal = (item_reg.signal_strength < rssi_threshold_reg);
        status.full       = (count_reg >= CNT_W'(TABLE_DEPTH));
        status.empty      = (count_reg == '0);
        status.hit        = rd_valid_reg && (rd_data_reg == key);
        status.end_miss   = rd_valid_reg && rd_last_reg && (rd_data_reg != key);
    end

    assign out_item = out_reg;

    // configuration; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rssi_threshold_reg <= RSSI_THRESHOLD_RST;
            type_mask_reg      <= TYPE_MASK_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_RSSI_THRESHOLD)
            begin
                rssi_threshold_reg <= $signed(cfg_data);
            end
            if (cfg_index == CFG_TYPE_MASK)
            begin
                type_mask_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.clear)
        begin
            count_reg <= '0;
        end
        else if (cmd.append)
        begin
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            table_mem[count_reg[IDX_W-1:0]] <= key;
        end
        rd_data_reg <= table_mem[scan_idx_reg];
    end

    // scan pipeline: one entry issued per cycle, compared after the registered read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg   <= '0;
            issue_done_reg <= 1'b0;
            rd_valid_reg   <= 1'b0;
            rd_last_reg    <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            scan_idx_reg   <= '0;
            issue_done_reg <= 1'b0;
            rd_valid_reg   <= 1'b0;
            rd_last_reg    <= 1'b0;
        end
        else if (cmd.scan_en && !issue_done_reg)
        begin
            rd_valid_reg   <= 1'b1;
            rd_last_reg    <= scan_is_last;
            issue_done_reg <= scan_is_last;
            scan_idx_reg   <= scan_next_cnt[IDX_W-1:0];
        end
        else
        begin
            rd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= in_item;
        end
        if (cmd.set_verdict)
        begin
            verdict_reg <= cmd.verdict;
            slot_reg    <= '0;
        end
        else if (cmd.append)
        begin
            verdict_reg <= VERDICT_ADDED;
            slot_reg    <= count_reg[IDX_W-1:0];
        end
        if (cmd.load_out)
        begin
            out_reg.verdict     <= verdict_reg;
            out_reg.slot        <= 4'(slot_reg);
            out_reg.entry_count <= 5'(count_reg);
        end
    end

endmodule

FILE: rtl/ble_scan_dedup_filter_top.sv
// Scan duplicate filter top level. Clears and early rejects (type, signal, full)
// go from the check straight to the result; duplicates and appends walk the
// stored entries first (an empty list appends without a walk). One item at a
// time: the next item is taken in the cycle after the result is registered. A
// full list is rejected before any walk. The table walk reads one entry per
// cycle on one read port.
// Reset (rst_n, async, low) empties the list and loads threshold -50, mask 35.
//
// Depends on bsdf_pkg, bsdf_ctrl and bsdf_datapath.
module ble_scan_dedup_filter_top
    import bsdf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // report / clear command channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_item,
    // result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_item,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // Config transfers are always taken; the user must issue them only while idle, the block does not enforce it.
    assign cfg_ready = 1'b1;

    // Controller: walks check -> scan -> append -> result (scan and append only as needed), one item at a time.
    bsdf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (dp_status),
        .cmd       (dp_cmd)
    );

    // Datapath: table memory, count, config registers and result register.
    bsdf_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (dp_cmd),
        .status    (dp_status),
        .out_item  (out_item)
    );

endmodule

FILE: bench/ble_scan_dedup_filter_top_test.sv
// Self-checking bench for the scan duplicate filter: directed and random reports,
// clears and register writes, with stalls on both channels and a scoreboard.
// Depends on bsdf_pkg and ble_scan_dedup_filter_top.
`timescale 1ns / 100ps

module ble_scan_dedup_filter_top_test;

    import bsdf_pkg::*;

    // Bench constants
    localparam int CLK_HALF       = 6;      // 12 ns period
    localparam int RESET_CYCLES   = 11;
    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no transfer of any kind
    localparam int RX_LONG_HOLD   = 400;    // long result stall, fills the block
    localparam int DRAIN_PAD      = 30;     // wait after the last result, to catch strays
    localparam int MAX_REPORTED   = 10;
    localparam int POOL_SIZE      = 24;     // more keys than entries, so the list fills
    localparam int RANDOM_PHASES  = 9;
    localparam int PHASE_ITEMS    = 150;
    localparam int QUIET_ITEMS    = 100;

    // Index beyond the register file; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 8'hFF;

    // ------------------------------------------------------------------
    // DUT connections, all inputs known from time zero
    // ------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_item_t              in_item   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    ble_scan_dedup_filter_top DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow of the filter: stored keys, count and both registers.
    // Keys are {address_kind, device_address}, as the block stores them.
    // ------------------------------------------------------------------
    logic [KEY_W-1:0]  known_keys [TABLE_DEPTH];
    int                known_count = 0;
    logic signed [7:0] rssi_floor  = RSSI_THRESHOLD_RST;
    logic [7:0]        conn_mask   = TYPE_MASK_RST;

    out_item_t         outcomes_due[$];     // predicted results, oldest first
    logic [KEY_W-1:0]  device_pool [POOL_SIZE];

    int  verdict_tally [6];
    int  items_sent      = 0;
    int  results_checked = 0;
    int  reg_writes      = 0;
    int  mismatch_count  = 0;
    int  quiet_cycles    = 0;

    // Idling controls; the sender side keeps track of whether valid is up
    bit  tx_idle_on   = 1'b1;
    bit  rx_idle_on   = 1'b1;
    bit  tx_offering  = 1'b0;
    bit  rx_hold_req  = 1'b0;
    int  rx_idle_left = 0;

    // Predict one transfer and advance the shadow state. The checks run in the
    // block's order: connectable type, signal floor, list full, duplicate key.
    // A full list therefore reports full even for a key already stored.
    function automatic out_item_t screen_report(input in_item_t it);
        out_item_t        res;
        logic [KEY_W-1:0] key;
        logic             seen;
        res  = '0;
        key  = {it.address_kind, it.device_address};
        seen = 1'b0;
        if (it.cmd == CMD_CLEAR)
        begin
            // stored keys are left as they are; only entries below the count matter
            known_count = 0;
            res.verdict = VERDICT_CLEARED;
        end
        else if (!conn_mask[it.advert_kind])
            res.verdict = VERDICT_NOT_CONN;
        else if ($signed(it.signal_strength) < $signed(rssi_floor))
            res.verdict = VERDICT_WEAK;
        else if (known_count >= TABLE_DEPTH)
            res.verdict = VERDICT_FULL;
        else
        begin
            for (int i = 0; i < known_count; i++)
                if (known_keys[i] == key)
                    seen = 1'b1;
            if (seen)
                res.verdict = VERDICT_DUP;
            else
            begin
                known_keys[known_count] = key;
                res.slot    = 4'(known_count);
                known_count = known_count + 1;
                res.verdict = VERDICT_ADDED;
            end
        end
        res.entry_count = 5'(known_count);
        verdict_tally[res.verdict]++;
        return res;
    endfunction

    function automatic in_item_t advert_report(input logic [ADDR_W-1:0] addr,
                                               input logic [KIND_W-1:0] kind,
                                               input logic [2:0]        adv,
                                               input logic signed [7:0] rssi);
        in_item_t it;
        it.cmd             = CMD_REPORT;
        it.device_address  = addr;
        it.address_kind    = kind;
        it.advert_kind     = adv;
        it.signal_strength = rssi;
        return it;
    endfunction

    // Random traffic. Most reports reuse keys from a small pool so duplicates
    // and a full list come up often; most pick an accepted type and a signal
    // at or above the floor so they reach the table walk. Clears are rare so
    // the list has room to fill between them.
    function automatic in_item_t make_random_item();
        in_item_t it;
        int       floor_i;
        int       v;
        floor_i            = rssi_floor;
        it.cmd             = CMD_REPORT;
        it.device_address  = {16'($urandom_range(0, 65535)), 32'($urandom())};
        it.address_kind    = 2'($urandom_range(0, 3));
        it.advert_kind     = 3'($urandom_range(0, 7));
        it.signal_strength = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 39) == 0)
            it.cmd = CMD_CLEAR;
        else
        begin
            if ($urandom_range(0, 99) < 65)
                {it.address_kind, it.device_address} =
                    device_pool[$urandom_range(0, POOL_SIZE - 1)];
            if (conn_mask != 8'h00 && $urandom_range(0, 3) != 0)
                while (!conn_mask[it.advert_kind])
                    it.advert_kind = 3'($urandom_range(0, 7));
            if ($urandom_range(0, 9) < 7)
            begin
                v = $urandom_range(floor_i + 128, 255) - 128;
                it.signal_strength = 8'(v);
            end
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Sender: one report or clear per call. Valid is only dropped for an idle
    // burst, so back-to-back transfers keep it high without a glitch.
    // ------------------------------------------------------------------
    task automatic send_item(input in_item_t it);
        if (tx_idle_on && $urandom_range(0, 4) == 0)
        begin
            if (tx_offering)
            begin
                in_valid    <= 1'b0;
                tx_offering = 1'b0;
            end
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        in_item     <= it;
        tx_offering = 1'b1;
        do @(posedge clk); while (!in_ready);
        outcomes_due.push_back(screen_report(it));
        items_sent++;
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic settle_block();
        if (tx_offering)
        begin
            in_valid    <= 1'b0;
            tx_offering = 1'b0;
        end
        do @(posedge clk); while (outcomes_due.size() != 0);
    endtask

    // One register write transfer; the caller lowers cfg_valid after the last
    task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_RSSI_THRESHOLD)
            rssi_floor = data;
        else if (idx == CFG_TYPE_MASK)
            conn_mask = data;
        reg_writes++;
    endtask

    task automatic reconfigure(input logic [7:0] threshold, input logic [7:0] mask);
        settle_block();
        write_reg(CFG_RSSI_THRESHOLD, threshold);
        write_reg(CFG_TYPE_MASK, mask);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall bursts, plus one long hold on request
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rx_hold_req)
        begin
            rx_hold_req  = 1'b0;
            rx_idle_left = RX_LONG_HOLD;
        end
        else if (rx_idle_left == 0 && rx_idle_on && $urandom_range(0, 5) == 0)
            rx_idle_left = $urandom_range(1, 6);
        if (rx_idle_left != 0)
        begin
            out_ready    <= 1'b0;
            rx_idle_left = rx_idle_left - 1;
        end
        else
            out_ready <= 1'b1;
    end

    // Scoreboard: every result transfer against the oldest prediction
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_checked++;
            if (outcomes_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTED)
                    $display("%0t: result with nothing pending: verdict %0d slot %0d count %0d",
                             $realtime, out_item.verdict, out_item.slot, out_item.entry_count);
            end
            else
            begin
                want = outcomes_due.pop_front();
                if (out_item.verdict !== want.verdict || out_item.slot !== want.slot ||
                    out_item.entry_count !== want.entry_count)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTED)
                    begin
                        $write("%0t: mismatch on result %0d: ", $realtime, results_checked);
                        $write("expected verdict %0d slot %0d count %0d, ",
                               want.verdict, want.slot, want.entry_count);
                        $display("got verdict %0d slot %0d count %0d",
                                 out_item.verdict, out_item.slot, out_item.entry_count);
                    end
                end
            end
        end
    end

    // Watchdog on transfers of any kind; the long hold is well inside it
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles = quiet_cycles + 1;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("%0t: watchdog, no transfer for %0d cycles, %0d results pending",
                             $realtime, quiet_cycles, outcomes_due.size());
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings (floor -50, types 0, 1 and 5): each rejection in order,
    // the floor boundary, address extremes and the address type in the key.
    task automatic test_report_checks();
        send_item('1);     // clear on an empty list, every other field set
        send_item(advert_report(48'h0, 2'd0, 3'd0, -8'sd50));            // at the floor
        send_item(advert_report(48'hFFFF_FFFF_FFFF, 2'd3, 3'd5, 8'sd127));
        send_item(advert_report(48'h0, 2'd0, 3'd1, 8'sd0));              // duplicate
        send_item(advert_report(48'h0, 2'd1, 3'd0, 8'sd0));              // other type, new key
        send_item(advert_report(48'h1234_5678_9ABC, 2'd0, 3'd2, 8'sd127)); // not connectable
        send_item(advert_report(48'h1234_5678_9ABC, 2'd0, 3'd0, -8'sd51)); // just below floor
        send_item(advert_report(48'h1234_5678_9ABC, 2'd2, 3'd7, 8'sh80)); // both fail: type wins
        send_item(advert_report(48'h1234_5678_9ABC, 2'd2, 3'd1, 8'sh80)); // weakest signal
    endtask

    // Fill all sixteen entries, then a stored key and a new key are both
    // full; a weak report stays weak since that check comes first.
    task automatic test_full_list();
        in_item_t wipe;
        for (int i = 0; i < TABLE_DEPTH - 3; i++)
            send_item(advert_report(48'h0000_0000_1000 + i, 2'(i), 3'd0, 8'sd0));
        send_item(advert_report(48'hFFFF_FFFF_FFFF, 2'd3, 3'd5, 8'sd10));
        send_item(advert_report(48'hA5A5_5A5A_A5A5, 2'd1, 3'd1, 8'sd10));
        send_item(advert_report(48'hA5A5_5A5A_A5A5, 2'd1, 3'd1, -8'sd100));
        wipe = advert_report(48'h5A5A_A5A5_5A5A, 2'd2, 3'd6, -8'sd1);
        wipe.cmd = CMD_CLEAR;
        send_item(wipe);
    endtask

    // Register extremes, and a write to an unused index that must be ignored
    task automatic test_register_extremes();
        reconfigure(8'h80, 8'h00);
        send_item(advert_report(48'h0000_0000_0001, 2'd0, 3'd0, 8'sh80));
        send_item(advert_report(48'h0000_0000_0002, 2'd3, 3'd7, 8'sd127));
        settle_block();
        write_reg(CFG_UNUSED_IDX, 8'hFF);
        cfg_valid <= 1'b0;
        send_item(advert_report(48'h0000_0000_0003, 2'd1, 3'd3, 8'sd0));
        reconfigure(8'h7F, 8'hFF);
        send_item(advert_report(48'h0000_0000_0004, 2'd2, 3'd3, 8'sd126));
        send_item(advert_report(48'h0000_0000_0004, 2'd2, 3'd7, 8'sd127));
        reconfigure(8'h80, 8'hFF);
        send_item(advert_report(48'h8000_0000_0000, 2'd0, 3'd4, 8'sh80));
        reconfigure(RSSI_THRESHOLD_RST, TYPE_MASK_RST);
    endtask

    // Hold the result side for a long stretch while reports keep coming, so
    // the block backs up and drops in_ready until the hold ends.
    task automatic test_output_backpressure();
        tx_idle_on  = 1'b0;
        rx_hold_req = 1'b1;
        repeat (8) send_item(make_random_item());
        tx_idle_on = 1'b1;
        settle_block();
    endtask

    // Random phases, each under its own settings; the first two use the extreme thresholds
    task automatic test_random_traffic();
        logic [7:0] threshold;
        logic [7:0] mask;
        for (int i = 0; i < POOL_SIZE; i++)
            device_pool[i] = {2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                              32'($urandom())};
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            unique case (ph)
                0:
                begin
                    threshold = 8'h80;
                    mask      = 8'hFF;
                end
                1:
                begin
                    threshold = 8'h7F;
                    mask      = 8'($urandom_range(1, 255));
                end
                2:
                begin
                    threshold = RSSI_THRESHOLD_RST;
                    mask      = TYPE_MASK_RST;
                end
                default:
                begin
                    if ($urandom_range(0, 1) == 0)
                        threshold = 8'($urandom_range(0, 255));
                    else
                        threshold = 8'(int'($urandom_range(0, 60)) - 80);
                    mask = 8'($urandom_range(0, 255));
                end
            endcase
            reconfigure(threshold, mask);
            repeat (PHASE_ITEMS) send_item(make_random_item());
        end
    endtask

    // Closing stretch with both sides at full rate
    task automatic test_quiet_traffic();
        reconfigure(RSSI_THRESHOLD_RST, TYPE_MASK_RST);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (QUIET_ITEMS) send_item(make_random_item());
    endtask

    // ------------------------------------------------------------------
    // Sequence: reset once, tests in turn, drain, verdict
    // ------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_report_checks();
        test_full_list();
        test_register_extremes();
        test_output_backpressure();
        test_random_traffic();
        test_quiet_traffic();

        // Everything sent: wait for the last result, then watch for strays
        settle_block();
        repeat (DRAIN_PAD) @(posedge clk);

        $write("Sent %0d transfers, checked %0d results: ", items_sent, results_checked);
        $write("%0d added, %0d duplicate, %0d full, ", verdict_tally[VERDICT_ADDED],
               verdict_tally[VERDICT_DUP], verdict_tally[VERDICT_FULL]);
        $display("%0d weak, %0d not connectable, %0d cleared", verdict_tally[VERDICT_WEAK],
                 verdict_tally[VERDICT_NOT_CONN], verdict_tally[VERDICT_CLEARED]);
        $display("%0d register writes over %0d settings, one %0d-cycle result hold, %0d mismatches",
                 reg_writes, RANDOM_PHASES + 5, RX_LONG_HOLD, mismatch_count);
        if (mismatch_count == 0 && outcomes_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
